// File: hw/rtl/bpa_pkg.sv
// Shared types, codes and default sizes for the buddy page allocator.
// Used by bpa_ctrl, bpa_datapath and buddy_page_allocator_core; no dependencies.
package bpa_pkg;

	localparam int NUM_PAGES_DEF  = 4096;
	localparam int MAX_ORDER_DEF  = 10;
	localparam int PAGE_SHIFT_DEF = 12;

	localparam int ADDR_W    = 48;
	localparam int KIND_W    = 2;
	localparam int ORD_W     = 4;
	localparam int STAT_W    = 2;
	localparam int FP_W      = 13;
	localparam int K_W       = 5;
	localparam int CFG_IDX_W = 1;
	localparam int OP_W      = 5;

	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOBLK  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_REJECT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 1'd1;

	// datapath operations, one per cycle
	localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD       = 5'd1;
	localparam logic [OP_W-1:0] OP_DISPATCH   = 5'd2;
	localparam logic [OP_W-1:0] OP_CLR_START  = 5'd3;
	localparam logic [OP_W-1:0] OP_CLR        = 5'd4;
	localparam logic [OP_W-1:0] OP_INIT_A     = 5'd5;
	localparam logic [OP_W-1:0] OP_INIT_B     = 5'd6;
	localparam logic [OP_W-1:0] OP_CARVE      = 5'd7;
	localparam logic [OP_W-1:0] OP_REL_CHECK  = 5'd8;
	localparam logic [OP_W-1:0] OP_REL_EVAL   = 5'd9;
	localparam logic [OP_W-1:0] OP_REL_CLR    = 5'd10;
	localparam logic [OP_W-1:0] OP_PUSH1      = 5'd11;
	localparam logic [OP_W-1:0] OP_PUSH2      = 5'd12;
	localparam logic [OP_W-1:0] OP_REL_DONE   = 5'd13;
	localparam logic [OP_W-1:0] OP_FREE_CHECK = 5'd14;
	localparam logic [OP_W-1:0] OP_SEARCH     = 5'd15;
	localparam logic [OP_W-1:0] OP_UNLINK     = 5'd16;
	localparam logic [OP_W-1:0] OP_TK_CLR     = 5'd17;
	localparam logic [OP_W-1:0] OP_SPLIT      = 5'd18;
	localparam logic [OP_W-1:0] OP_TK_FIN     = 5'd19;
	localparam logic [OP_W-1:0] OP_EMIT       = 5'd20;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ORD_W-1:0]  order;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] block_address;
		logic [FP_W-1:0]   page_count;
	} rsp_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [STAT_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic ord_bad;
		logic free_bad;
		logic init_empty;
		logic carve_end;
		logic rel_stop;
		logic rel_merge;
		logic head_ok;
		logic search_fail;
		logic split_done;
		logic half_ok;
		logic clr_last;
	} dp_status_t;

endpackage

// File: hw/rtl/bpa_ctrl.sv
// Sequencer of the buddy page allocator: one datapath operation per cycle.
// Depends on bpa_pkg.
module bpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bpa_pkg::dp_status_t st,
	output bpa_pkg::cmd_t       cmd,
	output logic                busy
);
	import bpa_pkg::*;

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_DISPATCH  = 5'd1;
	localparam logic [4:0] S_CLR_START = 5'd2;
	localparam logic [4:0] S_CLR       = 5'd3;
	localparam logic [4:0] S_INIT_A    = 5'd4;
	localparam logic [4:0] S_INIT_B    = 5'd5;
	localparam logic [4:0] S_CARVE     = 5'd6;
	localparam logic [4:0] S_REL_CHK   = 5'd7;
	localparam logic [4:0] S_REL_EVAL  = 5'd8;
	localparam logic [4:0] S_REL_CLR   = 5'd9;
	localparam logic [4:0] S_PUSH1     = 5'd10;
	localparam logic [4:0] S_PUSH2     = 5'd11;
	localparam logic [4:0] S_REL_DONE  = 5'd12;
	localparam logic [4:0] S_FREE_CHK  = 5'd13;
	localparam logic [4:0] S_SEARCH    = 5'd14;
	localparam logic [4:0] S_TK_UNL    = 5'd15;
	localparam logic [4:0] S_TK_CLR    = 5'd16;
	localparam logic [4:0] S_SPLIT     = 5'd17;
	localparam logic [4:0] S_TK_FIN    = 5'd18;
	localparam logic [4:0] S_EMIT      = 5'd19;

	localparam logic [1:0] M_RESET = 2'd0;
	localparam logic [1:0] M_ALLOC = 2'd1;
	localparam logic [1:0] M_FREE  = 2'd2;
	localparam logic [1:0] M_INIT  = 2'd3;

	logic [4:0]        state_q, state_d;
	logic [1:0]        mode_q, mode_d;
	logic [STAT_W-1:0] code_q, code_d;

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		code_d  = code_q;
		cmd.op  = OP_NOP;
		cmd.code = code_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LOAD;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.op = OP_DISPATCH;
				code_d = STAT_REJECT;
				case (st.kind)
					KIND_ALLOC: begin
						mode_d  = M_ALLOC;
						state_d = st.ord_bad ? S_EMIT : S_SEARCH;
					end
					KIND_FREE: begin
						mode_d  = M_FREE;
						state_d = S_FREE_CHK;
					end
					KIND_INIT: begin
						mode_d  = M_INIT;
						state_d = S_CLR_START;
					end
					default: state_d = S_EMIT;
				endcase
			end
			S_CLR_START: begin
				cmd.op  = OP_CLR_START;
				state_d = S_CLR;
			end
			S_CLR: begin
				cmd.op = OP_CLR;
				if (st.clr_last)
					state_d = (mode_q == M_INIT) ? S_INIT_A : S_IDLE;
			end
			S_INIT_A: begin
				cmd.op  = OP_INIT_A;
				state_d = S_INIT_B;
			end
			S_INIT_B: begin
				cmd.op = OP_INIT_B;
				code_d = STAT_OK;
				state_d = st.init_empty ? S_EMIT : S_CARVE;
			end
			S_CARVE: begin
				cmd.op = OP_CARVE;
				code_d = STAT_OK;
				state_d = st.carve_end ? S_EMIT : S_REL_CHK;
			end
			S_REL_CHK: begin
				cmd.op  = OP_REL_CHECK;
				state_d = st.rel_stop ? S_PUSH1 : S_REL_EVAL;
			end
			S_REL_EVAL: begin
				cmd.op  = OP_REL_EVAL;
				state_d = st.rel_merge ? S_REL_CLR : S_PUSH1;
			end
			S_REL_CLR: begin
				cmd.op  = OP_REL_CLR;
				state_d = S_REL_CHK;
			end
			S_PUSH1: begin
				cmd.op  = OP_PUSH1;
				state_d = S_PUSH2;
			end
			S_PUSH2: begin
				cmd.op  = OP_PUSH2;
				state_d = (mode_q == M_ALLOC) ? S_SPLIT : S_REL_DONE;
			end
			S_REL_DONE: begin
				cmd.op = OP_REL_DONE;
				code_d = STAT_OK;
				state_d = (mode_q == M_INIT) ? S_CARVE : S_EMIT;
			end
			S_FREE_CHK: begin
				cmd.op = OP_FREE_CHECK;
				code_d = STAT_REJECT;
				state_d = st.free_bad ? S_EMIT : S_REL_CHK;
			end
			S_SEARCH: begin
				cmd.op = OP_SEARCH;
				if (st.head_ok) begin
					state_d = S_TK_UNL;
				end else if (st.search_fail) begin
					code_d  = STAT_NOBLK;
					state_d = S_EMIT;
				end
			end
			S_TK_UNL: begin
				cmd.op  = OP_UNLINK;
				state_d = S_TK_CLR;
			end
			S_TK_CLR: begin
				cmd.op  = OP_TK_CLR;
				state_d = S_SPLIT;
			end
			S_SPLIT: begin
				cmd.op = OP_SPLIT;
				if (st.split_done)
					state_d = S_TK_FIN;
				else if (st.half_ok)
					state_d = S_PUSH1;
			end
			S_TK_FIN: begin
				cmd.op  = OP_TK_FIN;
				code_d  = STAT_OK;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.op  = OP_EMIT;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_START;
			mode_q  <= M_RESET;
			code_q  <= STAT_OK;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			code_q  <= code_d;
		end
	end

	assign busy = (state_q != S_IDLE);

endmodule

// File: hw/rtl/bpa_datapath.sv
// Page map memories, free list heads, counters and result register.
// Depends on bpa_pkg; driven by bpa_ctrl through cmd_t.
module bpa_datapath #(
	parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
	parameter int MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF,
	parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpa_pkg::cmd_t                 cmd,
	input  bpa_pkg::req_t                 req,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata,
	output bpa_pkg::dp_status_t           st,
	output bpa_pkg::rsp_t                 result,
	output logic                          result_valid
);
	import bpa_pkg::*;

	localparam int IW  = $clog2(NUM_PAGES);
	localparam int LW  = IW + 1;
	localparam int IIW = IW + 1;
	localparam int EW  = IW + 18;
	localparam int HD  = MAX_ORDER + 1;
	localparam int HW  = $clog2(HD);
	localparam int OW  = ADDR_W + 2;
	localparam logic [LW-1:0] NONE = {LW{1'b1}};
	localparam logic [LW-1:0] NP_L = LW'(NUM_PAGES);
	localparam logic [EW-1:0] NP_E = EW'(NUM_PAGES);
	localparam logic [OW-1:0] SPAN = OW'(NUM_PAGES) << PAGE_SHIFT;
	localparam logic [OW-1:0] PAGE_M1 = (OW'(1) << PAGE_SHIFT) - OW'(1);

	logic [LW-1:0]    next_mem [NUM_PAGES];
	logic [LW-1:0]    prev_mem [NUM_PAGES];
	logic [ORD_W-1:0] order_mem [NUM_PAGES];
	logic             mark_mem [NUM_PAGES];

	logic [ADDR_W-1:0] base_q, first_q, res_addr_q;
	logic [KIND_W-1:0] kind_q;
	logic [ORD_W-1:0]  ord_q, rel_ord_q;
	logic [OW-1:0]     off_q;
	logic              le_q;
	logic [IW-1:0]     cur_q, buddy_q, idx_q;
	logic [K_W-1:0]    k_q;
	logic [IIW-1:0]    i_q, clr_q;
	logic [LW-1:0]     head_q [HD];
	logic [FP_W-1:0]   free_total_q;
	logic [LW-1:0]     rd_next_q, rd_prev_q;
	logic [ORD_W-1:0]  rd_order_q;
	logic              rd_mark_q;
	rsp_t              rsp_q;
	logic              valid_q;

	logic [HW-1:0]    hk;
	logic [LW-1:0]    head_sel, head_v;
	logic             head_valid, p_valid, n_valid, unlink_en;
	logic [EW-1:0]    buddy_e, half_e, i_e, remain_e, size_e, fidx_e;
	logic [K_W-1:0]   km1, kc;
	logic [OW-1:0]    offs, start_e;
	logic [IW-1:0]    fidx, rd_addr;
	logic             aligned, fits;

	logic             nx_we, pv_we, or_we, mk_we;
	logic [IW-1:0]    nx_wa, pv_wa, or_wa, mk_wa;
	logic [LW-1:0]    nx_wd, pv_wd;
	logic [ORD_W-1:0] or_wd;
	logic             mk_wd;

	assign hk         = k_q[HW-1:0];
	assign head_sel   = (k_q <= K_W'(MAX_ORDER)) ? head_q[hk] : NONE;
	assign head_valid = head_sel < NP_L;
	assign head_v     = head_valid ? head_sel : NONE;
	assign p_valid    = rd_prev_q < NP_L;
	assign n_valid    = rd_next_q < NP_L;
	assign unlink_en  = (cmd.op == OP_UNLINK) || ((cmd.op == OP_REL_EVAL) && st.rel_merge);

	assign buddy_e = EW'(cur_q) ^ (EW'(1) << k_q);
	assign km1     = k_q - K_W'(1);
	assign half_e  = EW'(idx_q) + (EW'(1) << km1);

	// largest aligned block that still fits before the end of memory
	assign i_e      = EW'(i_q);
	assign remain_e = NP_E - i_e;
	always_comb begin
		kc = '0;
		for (int j = 0; j <= MAX_ORDER; j++) begin
			if (((i_e & ((EW'(1) << j) - EW'(1))) == '0) && ((EW'(1) << j) <= remain_e))
				kc = K_W'(j);
		end
	end

	assign offs    = off_q >> PAGE_SHIFT;
	assign start_e = offs;
	assign fidx    = offs[IW-1:0];
	assign fidx_e  = EW'(fidx);
	assign size_e  = EW'(1) << ord_q;
	assign aligned = (fidx_e & (size_e - EW'(1))) == '0;
	assign fits    = (fidx_e + size_e) <= NP_E;

	always_comb begin
		st.kind        = kind_q;
		st.ord_bad     = ord_q > ORD_W'(MAX_ORDER);
		st.free_bad    = st.ord_bad || off_q[OW-1] || (off_q >= SPAN) || !aligned || !fits;
		st.init_empty  = !le_q && (start_e >= OW'(NUM_PAGES));
		st.carve_end   = i_q >= IIW'(NUM_PAGES);
		st.rel_stop    = (k_q >= K_W'(MAX_ORDER)) || (buddy_e >= NP_E);
		st.rel_merge   = rd_mark_q && (rd_order_q == k_q[ORD_W-1:0]);
		st.head_ok     = head_valid;
		st.search_fail = !head_valid && (k_q >= K_W'(MAX_ORDER));
		st.split_done  = k_q == K_W'(ord_q);
		st.half_ok     = half_e < NP_E;
		st.clr_last    = clr_q == IIW'(NUM_PAGES - 1);
	end

	assign rd_addr = (cmd.op == OP_SEARCH) ? head_sel[IW-1:0] : buddy_e[IW-1:0];

	// write ports of the page map
	always_comb begin
		nx_we = 1'b0; nx_wa = '0; nx_wd = NONE;
		pv_we = 1'b0; pv_wa = '0; pv_wd = NONE;
		or_we = 1'b0; or_wa = '0; or_wd = '0;
		mk_we = 1'b0; mk_wa = '0; mk_wd = 1'b0;
		unique case (cmd.op)
			OP_CLR: begin
				nx_we = 1'b1; nx_wa = clr_q[IW-1:0];
				pv_we = 1'b1; pv_wa = clr_q[IW-1:0];
				or_we = 1'b1; or_wa = clr_q[IW-1:0];
				mk_we = 1'b1; mk_wa = clr_q[IW-1:0];
			end
			OP_REL_CLR: begin
				nx_we = 1'b1; nx_wa = buddy_q;
				pv_we = 1'b1; pv_wa = buddy_q;
				mk_we = 1'b1; mk_wa = buddy_q;
			end
			OP_PUSH1: begin
				nx_we = 1'b1; nx_wa = cur_q; nx_wd = head_v;
				pv_we = 1'b1; pv_wa = cur_q;
				or_we = 1'b1; or_wa = cur_q; or_wd = k_q[ORD_W-1:0];
				mk_we = 1'b1; mk_wa = cur_q; mk_wd = 1'b1;
			end
			OP_PUSH2: begin
				pv_we = head_valid; pv_wa = head_sel[IW-1:0]; pv_wd = LW'(cur_q);
			end
			OP_TK_CLR: begin
				nx_we = 1'b1; nx_wa = idx_q;
				pv_we = 1'b1; pv_wa = idx_q;
				mk_we = 1'b1; mk_wa = idx_q;
			end
			OP_TK_FIN: begin
				or_we = 1'b1; or_wa = idx_q; or_wd = ord_q;
				mk_we = 1'b1; mk_wa = idx_q;
			end
			OP_FREE_CHECK: begin
				or_we = !st.free_bad; or_wa = fidx; or_wd = ord_q;
			end
			default: ;
		endcase
		if (unlink_en) begin
			nx_we = p_valid; nx_wa = rd_prev_q[IW-1:0];
			nx_wd = n_valid ? rd_next_q : NONE;
			pv_we = n_valid; pv_wa = rd_next_q[IW-1:0];
			pv_wd = p_valid ? rd_prev_q : NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (nx_we) next_mem[nx_wa] <= nx_wd;
		if (pv_we) prev_mem[pv_wa] <= pv_wd;
		if (or_we) order_mem[or_wa] <= or_wd;
		if (mk_we) mark_mem[mk_wa] <= mk_wd;
		rd_next_q  <= next_mem[rd_addr];
		rd_prev_q  <= prev_mem[rd_addr];
		rd_order_q <= order_mem[rd_addr];
		rd_mark_q  <= mark_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			first_q      <= '0;
			clr_q        <= '0;
			free_total_q <= '0;
			valid_q      <= 1'b0;
			for (int h = 0; h < HD; h++)
				head_q[h] <= NONE;
		end else begin
			valid_q <= (cmd.op == OP_EMIT);
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_BASE:  base_q  <= cfg_wdata;
					CFG_FIRST: first_q <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (cmd.op)
				OP_CLR_START: begin
					clr_q        <= '0;
					free_total_q <= '0;
					for (int h = 0; h < HD; h++)
						head_q[h] <= NONE;
				end
				OP_CLR:      clr_q <= clr_q + IIW'(1);
				OP_PUSH2:    head_q[hk] <= LW'(cur_q);
				OP_REL_DONE: free_total_q <= free_total_q + (FP_W'(1) << rel_ord_q);
				OP_TK_FIN:   free_total_q <= free_total_q - (FP_W'(1) << ord_q);
				default: ;
			endcase
			if (unlink_en && !p_valid)
				head_q[hk] <= n_valid ? rd_next_q : NONE;
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				kind_q     <= req.kind;
				ord_q      <= req.order;
				off_q      <= OW'(req.address) - OW'(base_q);
				res_addr_q <= '0;
			end
			OP_DISPATCH: k_q <= K_W'(ord_q);
			OP_INIT_A: begin
				le_q  <= first_q <= base_q;
				off_q <= OW'(first_q) - OW'(base_q) + PAGE_M1;
			end
			OP_INIT_B: i_q <= le_q ? '0 : start_e[IIW-1:0];
			OP_CARVE: begin
				cur_q     <= i_q[IW-1:0];
				k_q       <= kc;
				rel_ord_q <= kc[ORD_W-1:0];
			end
			OP_REL_CHECK: buddy_q <= buddy_e[IW-1:0];
			OP_REL_CLR: begin
				if (buddy_q < cur_q)
					cur_q <= buddy_q;
				k_q <= k_q + K_W'(1);
			end
			OP_REL_DONE: i_q <= i_q + (IIW'(1) << rel_ord_q);
			OP_FREE_CHECK: begin
				cur_q     <= fidx;
				k_q       <= K_W'(ord_q);
				rel_ord_q <= ord_q;
			end
			OP_SEARCH: begin
				if (head_valid)
					idx_q <= head_sel[IW-1:0];
				else
					k_q <= k_q + K_W'(1);
			end
			OP_SPLIT: begin
				if (!st.split_done) begin
					k_q   <= km1;
					cur_q <= half_e[IW-1:0];
				end
			end
			OP_TK_FIN: res_addr_q <= base_q + (ADDR_W'(idx_q) << PAGE_SHIFT);
			OP_EMIT: begin
				rsp_q.status        <= cmd.code;
				rsp_q.block_address <= res_addr_q;
				rsp_q.page_count    <= free_total_q;
			end
			default: ;
		endcase
	end

	assign result       = rsp_q;
	assign result_valid = valid_q;

endmodule

// File: hw/rtl/buddy_page_allocator_core.sv
// Top level of the buddy page allocator: sequencer plus page map datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
//
// A request beat is taken when start is high and busy is low; exactly one
// result beat follows, shown on result for a single cycle with result_valid
// high. The receiver cannot hold results off, so capture them in that cycle.
// The block works on one request at a time; each cycle performs one read or
// write step on the page map memories (next link, previous link, order,
// free mark), so the time per request is set by the split and merge walks.
// Busy stays high while a request is worked on. Allocate time grows with the
// lists looked at (up to MAX_ORDER + 1) and the split levels; free time grows
// with the merge levels, with one more step when the walk stops on a buddy
// that is not free; a rejected allocate, an unknown kind and a rejected free
// end early. Init holds busy for a clearing sweep over all NUM_PAGES pages
// (4096 pages by default) and setup, then for carving each block and its
// merges. The result beat shows in the first cycle with busy low, and the
// next beat may be taken at the edge that ends it. After reset the clearing
// sweep runs with busy high and no result beat; configuration writes are
// taken throughout. Configure base_address and first_free_address only
// while idle.
module buddy_page_allocator_core #(
	parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
	parameter int MAX_ORDER  = bpa_pkg::MAX_ORDER_DEF,
	parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  bpa_pkg::req_t                 req,
	output logic                          result_valid,
	output bpa_pkg::rsp_t                 result,
	input  logic                          cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bpa_pkg::ADDR_W-1:0]    cfg_wdata
);
	import bpa_pkg::*;

	cmd_t       cmd;
	dp_status_t st;

	// sequencer: walks split, merge and clearing loops one step a cycle
	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: page map memories, list heads, counters, result register
	bpa_datapath #(
		.NUM_PAGES  (NUM_PAGES),
		.MAX_ORDER  (MAX_ORDER),
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.st           (st),
		.result       (result),
		.result_valid (result_valid)
	);

endmodule
